// File: rtl/ifd_pkg.sv
package ifd_pkg;

  localparam int SampleBitsDefault = 16;

  localparam logic [2:0] CFG_ACCEL_LIMIT = 3'd0;
  localparam logic [2:0] CFG_ROT_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_CANCEL      = 3'd2;
  localparam logic [2:0] CFG_SETTLE      = 3'd3;
  localparam logic [2:0] CFG_STILL       = 3'd4;
  localparam logic [2:0] CFG_DOT_LIMIT   = 3'd5;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_IMPACT  = 2'd1;
  localparam logic [1:0] EV_POSSIBLE = 2'd2;
  localparam logic [1:0] EV_CONFIRM = 2'd3;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [15:0] rec_accel_x;
    logic signed [15:0] rec_accel_y;
    logic signed [15:0] rec_accel_z;
    logic signed [15:0] rec_rate_x;
    logic signed [15:0] rec_rate_y;
    logic signed [15:0] rec_rate_z;
    logic [31:0]        rec_time;
    logic [31:0]        rec_accel_square;
    logic [31:0]        rec_rate_square;
    logic [16:0]        rec_dot_square;
  } out_item_t;

  typedef struct packed {
    logic [14:0] impact_accel_limit;
    logic [14:0] impact_rotation_limit;
    logic [14:0] motion_cancel_limit;
    logic [15:0] settle_ms;
    logic [15:0] stillness_ms;
    logic [16:0] dot_square_limit;
  } cfg_t;

endpackage

// File: rtl/ifd_front.sv
// front: squares accel and gyro magnitudes, one product per cycle
module ifd_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int SQ_BITS = 2 * SAMPLE_BITS + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  ifd_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_stall,
  output ifd_pkg::in_item_t q_item,
  output logic [SQ_BITS-1:0] q_acc_sq,
  output logic [SQ_BITS-1:0] q_rot_sq,
  output logic              q_valid,
  input  logic              q_stall
);
  import ifd_pkg::*;

  in_item_t                 item;
  logic                     busy;
  logic [2:0]               step;
  logic [SQ_BITS-1:0]       acc;
  logic [SQ_BITS-1:0]       racc;
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] prod;

  assign in_stall = busy | q_valid;

  always_comb begin
    case (step)
      3'd0: opnd = SAMPLE_BITS'(item.accel_x);
      3'd1: opnd = SAMPLE_BITS'(item.accel_y);
      3'd2: opnd = SAMPLE_BITS'(item.accel_z);
      3'd3: opnd = SAMPLE_BITS'(item.rate_x);
      3'd4: opnd = SAMPLE_BITS'(item.rate_y);
      default: opnd = SAMPLE_BITS'(item.rate_z);
    endcase
    mag  = opnd[SAMPLE_BITS-1] ? SAMPLE_BITS'(-opnd) : SAMPLE_BITS'(opnd);
    prod = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      q_valid <= 1'b0;
      step    <= 3'd0;
    end else begin
      if (q_valid && !q_stall) q_valid <= 1'b0;
      if (!busy && !q_valid && in_valid) begin
        item <= in_item;
        busy <= 1'b1;
        step <= 3'd0;
        acc  <= '0;
        racc <= '0;
      end else if (busy) begin
        if (step < 3'd3) acc <= acc + SQ_BITS'(prod);
        else racc <= racc + SQ_BITS'(prod);
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy     <= 1'b0;
          q_valid  <= 1'b1;
          q_item   <= item;
          q_acc_sq <= acc;
          q_rot_sq <= racc + SQ_BITS'(prod);
        end
      end
    end
  end
endmodule

// File: rtl/ifd_back.sv
// back: mode machine, quaternion dot and the record
module ifd_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int SQ_BITS = 2 * SAMPLE_BITS + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  ifd_pkg::cfg_t      cfg,
  input  ifd_pkg::in_item_t  q_item,
  input  logic [SQ_BITS-1:0] q_acc_sq,
  input  logic [SQ_BITS-1:0] q_rot_sq,
  input  logic               q_valid,
  output logic               q_stall,
  output ifd_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall
);
  import ifd_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IMPACT = 2'd1;
  localparam logic [1:0] MODE_STILL  = 2'd2;

  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_DOT  = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [1:0]  mode;
  logic [31:0] mark_time;
  logic signed [15:0] start_q [4];
  logic signed [15:0] rec_motion [6];
  logic [31:0] rec_time, rec_asq, rec_rsq;
  logic [16:0] rec_dot;

  logic [2:0]  st;
  logic [1:0]  k;
  logic signed [34:0] dot;
  logic [28:0] dmag;
  logic [57:0] dsq_full;
  logic [16:0] dsq;
  logic signed [15:0] qa, qb;
  logic signed [31:0] qprod;
  logic [31:0] elapsed;
  logic [29:0] lim_acc, lim_rot, lim_can;

  assign q_stall = (st != ST_DONE) || out_valid;
  assign elapsed = q_item.now_ms - mark_time;
  assign lim_acc = cfg.impact_accel_limit * cfg.impact_accel_limit;
  assign lim_rot = cfg.impact_rotation_limit * cfg.impact_rotation_limit;
  assign lim_can = cfg.motion_cancel_limit * cfg.motion_cancel_limit;

  always_comb begin
    case (k)
      2'd0: begin qa = start_q[0]; qb = q_item.quat_w; end
      2'd1: begin qa = start_q[1]; qb = q_item.quat_x; end
      2'd2: begin qa = start_q[2]; qb = q_item.quat_y; end
      default: begin qa = start_q[3]; qb = q_item.quat_z; end
    endcase
    qprod    = qa * qb;
    dsq_full = dmag * dmag;
  end

  function automatic logic [31:0] sat32(input logic [SQ_BITS-1:0] v);
    if (v > SQ_BITS'(33'h0FFFFFFFF)) sat32 = 32'hFFFFFFFF;
    else sat32 = 32'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      mark_time <= '0;
      st        <= ST_WAIT;
      out_valid <= 1'b0;
      k         <= '0;
      rec_time  <= '0;
      rec_asq   <= '0;
      rec_rsq   <= '0;
      rec_dot   <= '0;
      for (int i = 0; i < 6; i++) rec_motion[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        ST_WAIT: begin
          if (q_valid && !out_valid) begin
            dot <= '0;
            k   <= '0;
            st  <= (mode == MODE_IMPACT && {16'd0, cfg.settle_ms} < elapsed)
                   ? ST_DOT : ST_DONE;
          end
        end
        ST_DOT: begin
          dot <= dot + 35'(qprod);
          k   <= k + 2'd1;
          if (k == 2'd3) st <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (dot > 35'sd268435456 || dot < -35'sd268435456) dmag <= 29'd268435456;
          else if (dot < 0) dmag <= 29'(-dot);
          else dmag <= 29'(dot);
          st <= ST_SQ;
        end
        ST_SQ: begin
          dsq <= 17'(dsq_full >> 40);
          st  <= ST_DONE;
        end
        default: begin
          // commit one item and present its result
          out_item.event_res <= EV_NONE;
          case (mode)
            MODE_IDLE: begin
              if (q_acc_sq > SQ_BITS'(lim_acc) && q_rot_sq > SQ_BITS'(lim_rot)) begin
                mode       <= MODE_IMPACT;
                mark_time  <= q_item.now_ms;
                start_q[0] <= q_item.quat_w;
                start_q[1] <= q_item.quat_x;
                start_q[2] <= q_item.quat_y;
                start_q[3] <= q_item.quat_z;
                out_item.event_res <= EV_IMPACT;
              end
            end
            MODE_IMPACT: begin
              if ({16'd0, cfg.settle_ms} < elapsed) begin
                if (dsq < cfg.dot_square_limit) begin
                  mode          <= MODE_STILL;
                  mark_time     <= q_item.now_ms;
                  rec_motion[0] <= 16'(SAMPLE_BITS'(q_item.accel_x));
                  rec_motion[1] <= 16'(SAMPLE_BITS'(q_item.accel_y));
                  rec_motion[2] <= 16'(SAMPLE_BITS'(q_item.accel_z));
                  rec_motion[3] <= 16'(SAMPLE_BITS'(q_item.rate_x));
                  rec_motion[4] <= 16'(SAMPLE_BITS'(q_item.rate_y));
                  rec_motion[5] <= 16'(SAMPLE_BITS'(q_item.rate_z));
                  rec_time      <= q_item.now_ms;
                  rec_asq       <= sat32(q_acc_sq);
                  rec_rsq       <= sat32(q_rot_sq);
                  rec_dot       <= dsq;
                  out_item.event_res <= EV_POSSIBLE;
                end else begin
                  mode <= MODE_IDLE;
                end
              end
            end
            MODE_STILL: begin
              if (q_rot_sq > SQ_BITS'(lim_can)) begin
                mode <= MODE_IDLE;
              end else if ({16'd0, cfg.stillness_ms} < elapsed) begin
                mode <= MODE_IDLE;
                out_item.event_res <= EV_CONFIRM;
              end
            end
            default: mode <= MODE_IDLE;
          endcase
          out_valid <= 1'b1;
          st        <= ST_WAIT;
        end
      endcase
    end
  end

  // record fields reflect the record after this item's update
  always_comb begin
    out_item.rec_accel_x      = rec_motion[0];
    out_item.rec_accel_y      = rec_motion[1];
    out_item.rec_accel_z      = rec_motion[2];
    out_item.rec_rate_x       = rec_motion[3];
    out_item.rec_rate_y       = rec_motion[4];
    out_item.rec_rate_z       = rec_motion[5];
    out_item.rec_time         = rec_time;
    out_item.rec_accel_square = rec_asq;
    out_item.rec_rate_square  = rec_rsq;
    out_item.rec_dot_square   = rec_dot;
  end
endmodule

// File: rtl/imu_fall_detector_core.sv
// imu fall detector
// request channel: in_valid / in_stall carry one imu sample (accel, gyro,
// orientation quaternion, millisecond time); a request is taken when
// in_valid is high and in_stall is low
// result channel: out_valid / out_stall carry exactly one result per request:
// the event code plus the stored possible-fall record
// front squares accel and gyro magnitudes on one shared multiplier; a
// one-entry queue sits between front and back
// back picks a request from the queue in ST_WAIT and commits it in ST_DONE;
// an impact-mode sample past settle time also passes ST_DOT for the quaternion
// dot (one product per cycle), then ST_CLAMP and ST_SQ
// a new request is taken only once the previous one has left the queue
// a stalled result holds in its register; the front still fills the queue,
// and in_stall is high while the front is busy or the queue is full
// synchronous reset returns to idle mode, clears mark time and the record,
// and loads register defaults
// configuration writes go through cfg_we / cfg_index / cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it
module imu_fall_detector_core #(
  parameter int SAMPLE_BITS = ifd_pkg::SampleBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  ifd_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_stall,
  output ifd_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall
);
  import ifd_pkg::*;

  localparam int SqBits = 2 * SAMPLE_BITS + 2;

  cfg_t              cfg;
  in_item_t          q_item;
  logic [SqBits-1:0] q_acc_sq, q_rot_sq;
  logic              q_valid, q_stall;

  // configuration registers, bits above each width dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.impact_accel_limit    <= 15'd5120;
      cfg.impact_rotation_limit <= 15'd2400;
      cfg.motion_cancel_limit   <= 15'd1280;
      cfg.settle_ms             <= 16'd500;
      cfg.stillness_ms          <= 16'd2000;
      cfg.dot_square_limit      <= 17'd55938;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_LIMIT: cfg.impact_accel_limit    <= cfg_data[14:0];
        CFG_ROT_LIMIT:   cfg.impact_rotation_limit <= cfg_data[14:0];
        CFG_CANCEL:      cfg.motion_cancel_limit   <= cfg_data[14:0];
        CFG_SETTLE:      cfg.settle_ms             <= cfg_data[15:0];
        CFG_STILL:       cfg.stillness_ms          <= cfg_data[15:0];
        CFG_DOT_LIMIT:   cfg.dot_square_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  ifd_front #(.SAMPLE_BITS(SAMPLE_BITS), .SQ_BITS(SqBits)) u_front (
    .clk, .rst, .in_item, .in_valid, .in_stall,
    .q_item, .q_acc_sq, .q_rot_sq, .q_valid, .q_stall
  );

  ifd_back #(.SAMPLE_BITS(SAMPLE_BITS), .SQ_BITS(SqBits)) u_back (
    .clk, .rst, .cfg, .q_item, .q_acc_sq, .q_rot_sq, .q_valid, .q_stall,
    .out_item, .out_valid, .out_stall
  );
endmodule
